// ===== rtl/m2a_pkg.sv =====
// shared types and defaults for the 2x2 matrix arithmetic unit
// no dependencies
package m2a_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_ELEM       = 4;
  localparam int MODE_W         = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 4'd0,
    MODE_ADDS   = 4'd1,
    MODE_SUB    = 4'd2,
    MODE_SUBS   = 4'd3,
    MODE_MATMUL = 4'd4,
    MODE_SCALE  = 4'd5,
    MODE_MATVEC = 4'd6,
    MODE_DET    = 4'd7,
    MODE_INV    = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    LK_ZERO,
    LK_ADD,
    LK_MUL,
    LK_DOT
  } lane_kind_e;

  typedef struct packed {
    lane_kind_e kind;
    logic       sub;
  } lane_ctrl_t;

endpackage

// ===== rtl/matrix2x2_alu.sv =====
// 2x2 matrix arithmetic unit in signed fixed point, top level
// depends on m2a_pkg, m2a_lane, m2a_div, m2a_merge
//
// usage: one request on the slave stream carries the mode in s_axis_tuser and
// matrix A, matrix B, the scalar and the vector in s_axis_tdata; it yields one
// result on the master stream with r_00..r_11 and det_value in m_axis_tdata and
// the singular and saturated flags in m_axis_tuser.
// all modes pass through the lane registers, the divider pipeline (one quotient
// bit per stage) and the merge output register, so results leave in order.
// throughput: one request per cycle unless the output stalls; five lanes (four
// elements, one determinant) each hold two multipliers and work in parallel, the
// merge stage combines them.
// reset: the pipeline empties, no result is pending.
// stall: when m_axis_tvalid is high and m_axis_tready low the whole pipeline
// holds and s_axis_tready drops; the result stays on the output register.
module matrix2x2_alu import m2a_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // a_00, a_01, a_10, a_11, b_00, b_01, b_10, b_11, scalar, vec_x, vec_y
  input  logic [((11*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // mode
  input  logic [MODE_W-1:0]                        s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // r_00, r_01, r_10, r_11, det_value
  output logic [((5*DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  // singular, saturated
  output logic [1:0]                               m_axis_tuser
);

  localparam int DW     = DATA_WIDTH;
  localparam int OUT_W  = ((5*DATA_WIDTH+7)/8)*8;
  localparam int QW     = DATA_WIDTH + FRAC_BITS;
  localparam int NL     = NUM_ELEM + 1;
  localparam int SIDE_W = 5*DATA_WIDTH + NUM_ELEM + 2;

  logic en;
  logic signed [DW-1:0] a [NUM_ELEM];
  logic signed [DW-1:0] b [NUM_ELEM];
  logic signed [DW-1:0] scl, vx, vy;
  mode_e mode;

  lane_ctrl_t           ctrl [NL];
  logic signed [DW-1:0] x0 [NL], y0 [NL], x1 [NL], y1 [NL];
  logic signed [DW-1:0] lres [NL];
  logic        [NL-1:0] lsat;

  logic                 v_a_q, v_b_q, inv_a_q, inv_b_q;
  logic signed [DW-1:0] a_a_q [NUM_ELEM];
  logic signed [DW-1:0] a_b_q [NUM_ELEM];
  logic signed [DW-1:0] num [NUM_ELEM];
  logic [SIDE_W-1:0]    side_in, side_out;

  logic                 d_valid;
  logic [QW-1:0]        quo [NUM_ELEM];
  logic [NUM_ELEM-1:0]  neg;
  logic signed [DW-1:0] s_lane [NUM_ELEM];
  logic [NUM_ELEM-1:0]  s_sat;
  logic signed [DW-1:0] s_det;
  logic                 s_det_sat, s_inv;

  logic signed [DW-1:0] r [NUM_ELEM];
  logic signed [DW-1:0] det_o;
  logic                 sing, sat;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign mode          = mode_e'(s_axis_tuser);

  always_comb begin
    for (int l = 0; l < NUM_ELEM; l++) begin
      a[l] = s_axis_tdata[l*DW +: DW];
      b[l] = s_axis_tdata[(l+4)*DW +: DW];
    end
    scl = s_axis_tdata[8*DW +: DW];
    vx  = s_axis_tdata[9*DW +: DW];
    vy  = s_axis_tdata[10*DW +: DW];
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      ctrl[l] = '{kind: LK_ZERO, sub: 1'b0};
      x0[l]   = '0;
      y0[l]   = '0;
      x1[l]   = '0;
      y1[l]   = '0;
    end
    unique case (mode) inside
      MODE_ADD, MODE_SUB: begin
        for (int l = 0; l < NUM_ELEM; l++) begin
          ctrl[l] = '{kind: LK_ADD, sub: (mode == MODE_SUB)};
          x0[l]   = a[l];
          y0[l]   = b[l];
        end
      end
      MODE_ADDS, MODE_SUBS: begin
        for (int l = 0; l < NUM_ELEM; l++) begin
          ctrl[l] = '{kind: LK_ADD, sub: (mode == MODE_SUBS)};
          x0[l]   = a[l];
          y0[l]   = scl;
        end
      end
      MODE_MATMUL: begin
        for (int l = 0; l < NUM_ELEM; l++) begin
          ctrl[l] = '{kind: LK_DOT, sub: 1'b0};
          x0[l]   = a[(l/2)*2];
          x1[l]   = a[(l/2)*2+1];
          y0[l]   = b[l%2];
          y1[l]   = b[2+(l%2)];
        end
      end
      MODE_SCALE: begin
        for (int l = 0; l < NUM_ELEM; l++) begin
          ctrl[l] = '{kind: LK_MUL, sub: 1'b0};
          x0[l]   = a[l];
          y0[l]   = scl;
        end
      end
      MODE_MATVEC: begin
        ctrl[0] = '{kind: LK_DOT, sub: 1'b0};
        x0[0] = a[0]; y0[0] = vx; x1[0] = a[1]; y1[0] = vy;
        ctrl[2] = '{kind: LK_DOT, sub: 1'b0};
        x0[2] = a[2]; y0[2] = vx; x1[2] = a[3]; y1[2] = vy;
      end
      MODE_DET, MODE_INV: begin
        ctrl[4] = '{kind: LK_DOT, sub: 1'b1};
        x0[4] = a[0]; y0[4] = a[3]; x1[4] = a[1]; y1[4] = a[2];
      end
      default: begin
        ctrl[0] = '{kind: LK_ZERO, sub: 1'b0};
      end
    endcase
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    m2a_lane #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctrl_i(ctrl[l]),
      .x0_i  (x0[l]),
      .y0_i  (y0[l]),
      .x1_i  (x1[l]),
      .y1_i  (y1[l]),
      .res_o (lres[l]),
      .sat_o (lsat[l])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
    end else if (en) begin
      v_a_q <= s_axis_tvalid;
      v_b_q <= v_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_a_q   <= a;
      a_b_q   <= a_a_q;
      inv_a_q <= (mode == MODE_INV);
      inv_b_q <= inv_a_q;
    end
  end

  // adjugate: a_11, -a_01, -a_10, a_00
  assign num[0] = a_b_q[3];
  assign num[1] = a_b_q[1];
  assign num[2] = a_b_q[2];
  assign num[3] = a_b_q[0];

  assign side_in = {inv_b_q, lsat[4], lres[4], lsat[3:0],
                    lres[3], lres[2], lres[1], lres[0]};

  m2a_div #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (SIDE_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v_b_q),
    .num_i  (num),
    .flip_i (4'b0110),
    .den_i  (lres[4]),
    .side_i (side_in),
    .valid_o(d_valid),
    .quo_o  (quo),
    .neg_o  (neg),
    .side_o (side_out)
  );

  always_comb begin
    for (int l = 0; l < NUM_ELEM; l++) begin
      s_lane[l] = side_out[l*DW +: DW];
    end
    s_sat     = side_out[4*DW +: NUM_ELEM];
    s_det     = side_out[4*DW+NUM_ELEM +: DW];
    s_det_sat = side_out[5*DW+NUM_ELEM];
    s_inv     = side_out[5*DW+NUM_ELEM+1];
  end

  m2a_merge #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (d_valid),
    .inv_i      (s_inv),
    .lane_i     (s_lane),
    .lane_sat_i (s_sat),
    .det_i      (s_det),
    .det_sat_i  (s_det_sat),
    .quo_i      (quo),
    .neg_i      (neg),
    .valid_o    (m_axis_tvalid),
    .r_o        (r),
    .det_o      (det_o),
    .singular_o (sing),
    .saturated_o(sat)
  );

  assign m_axis_tdata = OUT_W'({det_o, r[3], r[2], r[1], r[0]});
  assign m_axis_tuser = {sat, sing};

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("singular result carries nonzero data");

  a_sing_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
    else $error("singular result flagged saturated");

  a_stall_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while output stalled");

endmodule

// ===== rtl/m2a_lane.sv =====
// one arithmetic lane: two registered products or operands, then sum, shift and clip
// depends on m2a_pkg
module m2a_lane import m2a_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  lane_ctrl_t                   ctrl_i,
  input  logic signed [DATA_WIDTH-1:0] x0_i,
  input  logic signed [DATA_WIDTH-1:0] y0_i,
  input  logic signed [DATA_WIDTH-1:0] x1_i,
  input  logic signed [DATA_WIDTH-1:0] y1_i,
  output logic signed [DATA_WIDTH-1:0] res_o,
  output logic                         sat_o
);

  localparam int PW = 2 * DATA_WIDTH;

  logic signed [PW-1:0] p_d, q_d, p_q, q_q;
  lane_ctrl_t           ctrl_q;
  logic signed [PW:0]   sum, sh;
  logic                 fits;
  logic signed [DATA_WIDTH-1:0] res_d;

  always_comb begin
    p_d = '0;
    q_d = '0;
    case (ctrl_i.kind)
      LK_ADD: begin
        p_d = PW'(x0_i);
        q_d = PW'(y0_i);
      end
      LK_MUL: begin
        p_d = x0_i * y0_i;
      end
      LK_DOT: begin
        p_d = x0_i * y0_i;
        q_d = x1_i * y1_i;
      end
      default: begin
        p_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_d;
      q_q    <= q_d;
      ctrl_q <= ctrl_i;
    end
  end

  always_comb begin
    sum   = ctrl_q.sub ? ($signed({p_q[PW-1], p_q}) - $signed({q_q[PW-1], q_q}))
                       : ($signed({p_q[PW-1], p_q}) + $signed({q_q[PW-1], q_q}));
    sh    = (ctrl_q.kind == LK_ADD) ? sum : (sum >>> FRAC_BITS);
    fits  = (sh[PW:DATA_WIDTH-1] == {(DATA_WIDTH+2){sh[PW]}});
    res_d = fits ? sh[DATA_WIDTH-1:0]
          : (sh[PW] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_o <= 1'b0;
    end else if (en_i) begin
      sat_o <= !fits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule

// ===== rtl/m2a_div.sv =====
// pipelined restoring divider, four lanes sharing one divisor, one quotient bit per stage
// depends on m2a_pkg
module m2a_div import m2a_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int SIDE_W     = 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [DATA_WIDTH-1:0]          num_i [NUM_ELEM],
  input  logic        [NUM_ELEM-1:0]            flip_i,
  input  logic signed [DATA_WIDTH-1:0]          den_i,
  input  logic        [SIDE_W-1:0]              side_i,
  output logic                                  valid_o,
  output logic        [DATA_WIDTH+FRAC_BITS-1:0] quo_o [NUM_ELEM],
  output logic        [NUM_ELEM-1:0]            neg_o,
  output logic        [SIDE_W-1:0]              side_o
);

  localparam int QW = DATA_WIDTH + FRAC_BITS;

  logic [DATA_WIDTH-1:0] rem_q  [QW+1][NUM_ELEM];
  logic [QW-1:0]         n_q    [QW+1][NUM_ELEM];
  logic [QW-1:0]         quo_q  [QW+1][NUM_ELEM];
  logic [DATA_WIDTH-1:0] den_q  [QW+1];
  logic [NUM_ELEM-1:0]   neg_q  [QW+1];
  logic [SIDE_W-1:0]     side_q [QW+1];
  logic [QW:0]           vld_q;

  logic [DATA_WIDTH-1:0] nmag [NUM_ELEM];
  logic [DATA_WIDTH-1:0] dmag;

  always_comb begin
    dmag = den_i[DATA_WIDTH-1] ? DATA_WIDTH'(-den_i) : DATA_WIDTH'(den_i);
    for (int l = 0; l < NUM_ELEM; l++) begin
      nmag[l] = num_i[l][DATA_WIDTH-1] ? DATA_WIDTH'(-num_i[l]) : DATA_WIDTH'(num_i[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= dmag;
      side_q[0] <= side_i;
      for (int l = 0; l < NUM_ELEM; l++) begin
        rem_q[0][l] <= '0;
        n_q[0][l]   <= QW'(nmag[l]) << FRAC_BITS;
        quo_q[0][l] <= '0;
        neg_q[0][l] <= num_i[l][DATA_WIDTH-1] ^ den_i[DATA_WIDTH-1] ^ flip_i[l];
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;
    logic [DATA_WIDTH:0]   trial [NUM_ELEM];
    logic [DATA_WIDTH-1:0] rem_d [NUM_ELEM];
    logic [QW-1:0]         quo_d [NUM_ELEM];

    always_comb begin
      for (int l = 0; l < NUM_ELEM; l++) begin
        trial[l] = {rem_q[k-1][l], n_q[k-1][l][B]};
        quo_d[l] = quo_q[k-1][l];
        if (trial[l] >= {1'b0, den_q[k-1]}) begin
          rem_d[l]    = DATA_WIDTH'(trial[l] - {1'b0, den_q[k-1]});
          quo_d[l][B] = 1'b1;
        end else begin
          rem_d[l] = trial[l][DATA_WIDTH-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        for (int l = 0; l < NUM_ELEM; l++) begin
          rem_q[k][l] <= rem_d[l];
          n_q[k][l]   <= n_q[k-1][l];
          quo_q[k][l] <= quo_d[l];
        end
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign neg_o   = neg_q[QW];
  assign side_o  = side_q[QW];
  assign quo_o   = quo_q[QW];

endmodule

// ===== rtl/m2a_merge.sv =====
// merging stage: picks lane or quotient results, handles singular inverse, output register
// depends on m2a_pkg
module m2a_merge import m2a_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic                                   inv_i,
  input  logic signed [DATA_WIDTH-1:0]           lane_i [NUM_ELEM],
  input  logic        [NUM_ELEM-1:0]             lane_sat_i,
  input  logic signed [DATA_WIDTH-1:0]           det_i,
  input  logic                                   det_sat_i,
  input  logic        [DATA_WIDTH+FRAC_BITS-1:0] quo_i [NUM_ELEM],
  input  logic        [NUM_ELEM-1:0]             neg_i,
  output logic                                   valid_o,
  output logic signed [DATA_WIDTH-1:0]           r_o [NUM_ELEM],
  output logic signed [DATA_WIDTH-1:0]           det_o,
  output logic                                   singular_o,
  output logic                                   saturated_o
);

  localparam int QW = DATA_WIDTH + FRAC_BITS;

  logic signed [QW:0]           sv   [NUM_ELEM];
  logic signed [DATA_WIDTH-1:0] qc   [NUM_ELEM];
  logic        [NUM_ELEM-1:0]   qsat;
  logic signed [DATA_WIDTH-1:0] r_d  [NUM_ELEM];
  logic signed [DATA_WIDTH-1:0] det_d;
  logic                         sing_d, sat_d;

  always_comb begin
    for (int l = 0; l < NUM_ELEM; l++) begin
      sv[l]   = neg_i[l] ? -$signed({1'b0, quo_i[l]}) : $signed({1'b0, quo_i[l]});
      qsat[l] = (sv[l][QW:DATA_WIDTH-1] != {(QW-DATA_WIDTH+2){sv[l][QW]}});
      qc[l]   = !qsat[l] ? sv[l][DATA_WIDTH-1:0]
              : (sv[l][QW] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                           : {1'b0, {(DATA_WIDTH-1){1'b1}}});
    end
    det_d  = det_i;
    sing_d = 1'b0;
    if (!inv_i) begin
      r_d   = lane_i;
      sat_d = (|lane_sat_i) | det_sat_i;
    end else if (det_i == '0) begin
      for (int l = 0; l < NUM_ELEM; l++) r_d[l] = '0;
      sing_d = 1'b1;
      sat_d  = 1'b0;
    end else begin
      r_d   = qc;
      sat_d = (|qsat) | det_sat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o         <= r_d;
      det_o       <= det_d;
      singular_o  <= sing_d;
      saturated_o <= sat_d;
    end
  end

endmodule

// ===== tb/tb_matrix2x2_alu.sv =====
// self-checking testbench for the 2x2 matrix arithmetic unit
// depends on m2a_pkg and matrix2x2_alu; predicts each result in exact wide arithmetic
`timescale 1ns / 100ps

module tb_matrix2x2_alu;
  import m2a_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int IN_W = 11 * DW;
  localparam int OUT_W = 5 * DW;
  localparam int LATENCY = DW + FB + 4;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [3:0] mode;
    logic [DW-1:0] a [4];
    logic [DW-1:0] b [4];
    logic [DW-1:0] s;
    logic [DW-1:0] vx;
    logic [DW-1:0] vy;
  } mat_req_t;

  typedef struct {
    logic [DW-1:0] r [4];
    logic [DW-1:0] det;
    logic sing;
    logic sat;
  } mat_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic [MODE_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  mat_req_t pending_q[$];
  mat_res_t result_q[$];
  int errors = 0;
  longint cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_off = 0;
  bit hold_done = 1'b0;
  bit stim_done = 1'b0;

  matrix2x2_alu dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [DW-1:0] clip_val(logic signed [199:0] v, ref logic sat);
    logic signed [199:0] hi, lo;
    hi = (200'sd1 <<< (DW - 1)) - 1;
    lo = -(200'sd1 <<< (DW - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  function automatic logic signed [199:0] sx(logic [DW-1:0] v);
    return 200'(signed'(v));
  endfunction

  function automatic logic signed [199:0] dot_sum(logic [DW-1:0] x0, y0, x1, y1, bit neg);
    logic signed [199:0] p;
    p = neg ? sx(x0) * sx(y0) - sx(x1) * sx(y1) : sx(x0) * sx(y0) + sx(x1) * sx(y1);
    return p >>> FB;
  endfunction

  function automatic logic signed [199:0] quot(logic signed [199:0] num, logic signed [199:0] den);
    logic signed [199:0] n, d, q;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (n <<< FB) / d;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic mat_res_t predict_matrix_op(mat_req_t q);
    mat_res_t res;
    logic sat;
    logic signed [199:0] d;
    sat = 1'b0;
    foreach (res.r[i]) res.r[i] = '0;
    res.det = '0;
    res.sing = 1'b0;
    case (q.mode)
      MODE_ADD: foreach (res.r[i]) res.r[i] = clip_val(sx(q.a[i]) + sx(q.b[i]), sat);
      MODE_SUB: foreach (res.r[i]) res.r[i] = clip_val(sx(q.a[i]) - sx(q.b[i]), sat);
      MODE_ADDS: foreach (res.r[i]) res.r[i] = clip_val(sx(q.a[i]) + sx(q.s), sat);
      MODE_SUBS: foreach (res.r[i]) res.r[i] = clip_val(sx(q.a[i]) - sx(q.s), sat);
      MODE_MATMUL: begin
        res.r[0] = clip_val(dot_sum(q.a[0], q.b[0], q.a[1], q.b[2], 0), sat);
        res.r[1] = clip_val(dot_sum(q.a[0], q.b[1], q.a[1], q.b[3], 0), sat);
        res.r[2] = clip_val(dot_sum(q.a[2], q.b[0], q.a[3], q.b[2], 0), sat);
        res.r[3] = clip_val(dot_sum(q.a[2], q.b[1], q.a[3], q.b[3], 0), sat);
      end
      MODE_SCALE: foreach (res.r[i]) res.r[i] = clip_val((sx(q.a[i]) * sx(q.s)) >>> FB, sat);
      MODE_MATVEC: begin
        res.r[0] = clip_val(dot_sum(q.a[0], q.vx, q.a[1], q.vy, 0), sat);
        res.r[2] = clip_val(dot_sum(q.a[2], q.vx, q.a[3], q.vy, 0), sat);
      end
      MODE_DET, MODE_INV: begin
        res.det = clip_val(dot_sum(q.a[0], q.a[3], q.a[1], q.a[2], 1), sat);
        if (q.mode == MODE_INV) begin
          if (res.det == '0) begin
            res.sing = 1'b1;
          end else begin
            d = sx(res.det);
            res.r[0] = clip_val(quot(sx(q.a[3]), d), sat);
            res.r[1] = clip_val(quot(-sx(q.a[1]), d), sat);
            res.r[2] = clip_val(quot(-sx(q.a[2]), d), sat);
            res.r[3] = clip_val(quot(sx(q.a[0]), d), sat);
          end
        end
      end
      default: ;
    endcase
    res.sat = sat;
    return res;
  endfunction

  function automatic logic [DW-1:0] rand_val();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 8)) - 4) <<< FB;
      3: return 32'(signed'($urandom_range(0, 65535)) - 32768);
      4, 5: return 32'(signed'($urandom_range(0, 2 ** 21)) - 2 ** 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic mat_req_t rand_req(logic [3:0] mode);
    mat_req_t q;
    q.mode = mode;
    foreach (q.a[i]) q.a[i] = rand_val();
    foreach (q.b[i]) q.b[i] = rand_val();
    q.s = rand_val();
    q.vx = rand_val();
    q.vy = rand_val();
    return q;
  endfunction

  function automatic logic [IN_W-1:0] pack_req(mat_req_t q);
    return {q.vy, q.vx, q.s, q.b[3], q.b[2], q.b[1], q.b[0], q.a[3], q.a[2], q.a[1], q.a[0]};
  endfunction

  task automatic push_fill(logic [3:0] mode, logic [DW-1:0] v);
    mat_req_t q;
    q = rand_req(mode);
    foreach (q.a[i]) q.a[i] = v;
    foreach (q.b[i]) q.b[i] = v;
    q.s = v;
    q.vx = v;
    q.vy = v;
    pending_q.push_back(q);
  endtask

  initial begin
    mat_req_t q;
    // extremes for every mode, including undefined ones
    for (int m = 0; m < 16; m++) push_fill(4'(m), 32'h7fff_ffff);
    push_fill(MODE_ADD, 32'h8000_0000);
    push_fill(MODE_SCALE, 32'h8000_0000);
    push_fill(MODE_INV, 32'h0001_0000);
    // identity inverse and diagonal inverses with small determinants
    q = rand_req(MODE_INV);
    q.a[0] = 32'h0001_0000; q.a[1] = '0; q.a[2] = '0; q.a[3] = 32'h0001_0000;
    pending_q.push_back(q);
    q.a[3] = 32'h0000_0002;
    pending_q.push_back(q);
    q.a[0] = 32'h0000_0100; q.a[3] = 32'h0000_0100;
    pending_q.push_back(q);
    q = rand_req(MODE_MATVEC);
    q.a[0] = 32'hffff_ffff; q.vx = 32'h0000_0001;
    pending_q.push_back(q);
    for (int n = 0; n < 1100; n++) begin
      q = rand_req($urandom_range(0, 19) == 0 ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8)));
      pending_q.push_back(q);
    end
    stim_done = 1'b1;
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid) result_q.push_back(predict_matrix_op(pending_q.pop_front()));
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pack_req(pending_q[0]);
          s_axis_tuser <= pending_q[0].mode;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 40);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern with one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && cycles > 300) begin
        hold_off <= 150;
        hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if ((cycles / 500) % 2 == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= $urandom_range(0, 2) != 0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mat_res_t e;
    logic [OUT_W-1:0] exp_data;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result data=%h user=%b", $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        e = result_q.pop_front();
        exp_data = {e.det, e.r[3], e.r[2], e.r[1], e.r[0]};
        for (int i = 0; i < 5; i++)
          if (m_axis_tdata[i*DW +: DW] !== exp_data[i*DW +: DW]) begin
            $display("%0t: field %0d expected %h actual %h", $time, i,
                     exp_data[i*DW +: DW], m_axis_tdata[i*DW +: DW]);
            errors++;
          end
        if (m_axis_tuser !== {e.sat, e.sing}) begin
          $display("%0t: flags expected %b actual %b", $time, {e.sat, e.sing}, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && pending_q.size() == 0 && result_q.size() == 0 || cycles > CYCLE_LIMIT);
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix2x2_alu verification failed");
    end else begin
      repeat (LATENCY + 10) @(posedge clk_i);
      if (errors == 0) begin
        $display("matrix2x2_alu verification clean");
      end else begin
        $display("matrix2x2_alu verification failed");
      end
    end
    $finish;
  end

endmodule
